// File: rtl/rlsu_pkg.sv
// Shared types, constants and helpers for the run-limited sequence unranker.
// No dependencies; used by rlsu_ctrl, rlsu_dp, run_limited_sequence_unranker and tb_top.
`timescale 1ns / 1ps

package rlsu_pkg;

	// Default sizing of the count storage
	localparam int MAX_LEN_DEF   = 16;
	localparam int MAX_ALPHA_DEF = 16;
	localparam int MAX_RUN_DEF   = 16;

	// Fixed field widths
	localparam int CNT_W = 63;
	localparam int CFG_W = 5;
	localparam int IDX_W = 2;

	typedef logic [CNT_W-1:0] count_t;
	typedef logic [CFG_W-1:0] cfg_t;

	localparam count_t SAT_MAX = '1;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_ALPHABET_SIZE = 2'd0,
		REG_MAX_RUN       = 2'd1,
		REG_SEQ_LENGTH    = 2'd2
	} reg_idx_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F_START,
		ST_F_ADD,
		ST_F_WRITE,
		ST_W_READ,
		ST_W_ACC,
		ST_LEN_NEXT,
		ST_T_READ,
		ST_T_ADD,
		ST_T_CHECK,
		ST_G_READ,
		ST_G_TAKE,
		ST_H_TAKE,
		ST_SCAN
	} state_t;

	// Datapath commands
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_F_START,
		OP_F_ADD,
		OP_F_WRITE,
		OP_W_READ,
		OP_W_ACC,
		OP_LEN_NEXT,
		OP_T_READ,
		OP_T_ADD,
		OP_T_CHECK,
		OP_G_READ,
		OP_G_TAKE,
		OP_H_TAKE,
		OP_SCAN
	} dp_op_t;

	// Datapath status toward the controller
	typedef struct packed {
		logic len_one;   // length / position counter is 1
		logic len_last;  // length counter equals configured length
		logic a_one;     // single-symbol alphabet
		logic f_done;    // last multiply-by-add step for the leading count
		logic k_last;    // run counter reached max run
		logic j_last;    // symbol counter reached alphabet size
		logic rank_bad;  // rank zero or above the total
		logic h_used;    // repeat of the previous symbol is still allowed
		logic pick;      // scan settles on the current symbol
		logic cfg_hit;   // write to a known register
	} status_t;

	// Saturating add at 2^63-1
	function automatic count_t sat_add(input count_t x, input count_t y);
		logic [CNT_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[CNT_W] ? SAT_MAX : s[CNT_W-1:0];
	endfunction

	// Zero reads as one, above the top reads as the top
	function automatic cfg_t clamp_cfg(input cfg_t v, input logic [6:0] top);
		if (v == '0)
			return cfg_t'(1);
		if ({2'b00, v} > top)
			return top[CFG_W-1:0];
		return v;
	endfunction

endpackage

// File: rtl/rlsu_ctrl.sv
// Sequencer of the run-limited sequence unranker: table build, total check, decode.
// Depends on rlsu_pkg; drives rlsu_dp through dp_op_t commands and reads status_t.
`timescale 1ns / 1ps

module rlsu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rlsu_pkg::status_t st,
	output rlsu_pkg::dp_op_t  op,
	output logic              busy
);

	rlsu_pkg::state_t state_q, state_d;
	logic             ready_q;
	logic             set_ready;

	// State and table-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlsu_pkg::ST_IDLE;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (st.cfg_hit)
				ready_q <= 1'b0;
			else if (set_ready)
				ready_q <= 1'b1;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rlsu_pkg::ST_IDLE: begin
				if (start)
					state_d = ready_q ? rlsu_pkg::ST_T_READ : rlsu_pkg::ST_F_START;
			end
			rlsu_pkg::ST_F_START: begin
				if (st.len_one || st.a_one)
					state_d = rlsu_pkg::ST_F_WRITE;
				else
					state_d = rlsu_pkg::ST_F_ADD;
			end
			rlsu_pkg::ST_F_ADD: begin
				if (st.f_done)
					state_d = rlsu_pkg::ST_F_WRITE;
			end
			rlsu_pkg::ST_F_WRITE: state_d = rlsu_pkg::ST_W_READ;
			rlsu_pkg::ST_W_READ:  state_d = rlsu_pkg::ST_W_ACC;
			rlsu_pkg::ST_W_ACC: begin
				state_d = st.k_last ? rlsu_pkg::ST_LEN_NEXT : rlsu_pkg::ST_W_READ;
			end
			rlsu_pkg::ST_LEN_NEXT: begin
				state_d = st.len_last ? rlsu_pkg::ST_T_READ : rlsu_pkg::ST_F_START;
			end
			rlsu_pkg::ST_T_READ: state_d = rlsu_pkg::ST_T_ADD;
			rlsu_pkg::ST_T_ADD: begin
				if (st.j_last)
					state_d = rlsu_pkg::ST_T_CHECK;
			end
			rlsu_pkg::ST_T_CHECK: begin
				state_d = st.rank_bad ? rlsu_pkg::ST_IDLE : rlsu_pkg::ST_G_READ;
			end
			rlsu_pkg::ST_G_READ: state_d = rlsu_pkg::ST_G_TAKE;
			rlsu_pkg::ST_G_TAKE: begin
				state_d = st.h_used ? rlsu_pkg::ST_H_TAKE : rlsu_pkg::ST_SCAN;
			end
			rlsu_pkg::ST_H_TAKE: state_d = rlsu_pkg::ST_SCAN;
			rlsu_pkg::ST_SCAN: begin
				if (st.pick)
					state_d = st.len_one ? rlsu_pkg::ST_IDLE : rlsu_pkg::ST_G_READ;
			end
			default: state_d = rlsu_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		op        = rlsu_pkg::OP_NONE;
		set_ready = 1'b0;
		case (state_q)
			rlsu_pkg::ST_IDLE: begin
				if (start)
					op = rlsu_pkg::OP_LOAD;
			end
			rlsu_pkg::ST_F_START: op = rlsu_pkg::OP_F_START;
			rlsu_pkg::ST_F_ADD:   op = rlsu_pkg::OP_F_ADD;
			rlsu_pkg::ST_F_WRITE: op = rlsu_pkg::OP_F_WRITE;
			rlsu_pkg::ST_W_READ:  op = rlsu_pkg::OP_W_READ;
			rlsu_pkg::ST_W_ACC:   op = rlsu_pkg::OP_W_ACC;
			rlsu_pkg::ST_LEN_NEXT: begin
				if (st.len_last)
					set_ready = 1'b1;
				else
					op = rlsu_pkg::OP_LEN_NEXT;
			end
			rlsu_pkg::ST_T_READ:  op = rlsu_pkg::OP_T_READ;
			rlsu_pkg::ST_T_ADD:   op = rlsu_pkg::OP_T_ADD;
			rlsu_pkg::ST_T_CHECK: op = rlsu_pkg::OP_T_CHECK;
			rlsu_pkg::ST_G_READ:  op = rlsu_pkg::OP_G_READ;
			rlsu_pkg::ST_G_TAKE:  op = rlsu_pkg::OP_G_TAKE;
			rlsu_pkg::ST_H_TAKE:  op = rlsu_pkg::OP_H_TAKE;
			rlsu_pkg::ST_SCAN:    op = rlsu_pkg::OP_SCAN;
			default:              op = rlsu_pkg::OP_NONE;
		endcase
	end

	assign busy = (state_q != rlsu_pkg::ST_IDLE);

endmodule

// File: rtl/rlsu_dp.sv
// Datapath of the run-limited sequence unranker: config registers, count memories,
// saturating accumulator, rank scan and result registers. Depends on rlsu_pkg.
`timescale 1ns / 1ps

module rlsu_dp #(
	parameter int MAX_LEN   = rlsu_pkg::MAX_LEN_DEF,
	parameter int MAX_ALPHA = rlsu_pkg::MAX_ALPHA_DEF,
	parameter int MAX_RUN   = rlsu_pkg::MAX_RUN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rlsu_pkg::dp_op_t             op,
	input  rlsu_pkg::count_t             rank,
	input  logic                         cfg_we,
	input  logic [rlsu_pkg::IDX_W-1:0]   cfg_index,
	input  rlsu_pkg::cfg_t               cfg_data,
	output rlsu_pkg::status_t            st,
	output logic                         result_valid,
	output rlsu_pkg::cfg_t               symbol,
	output logic                         last,
	output logic                         error
);

	localparam int LW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int RW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int WD  = MAX_LEN * MAX_RUN;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
	localparam logic [6:0] ALPHA_TOP = 7'(MAX_ALPHA);
	localparam logic [6:0] RUN_TOP   = 7'(MAX_RUN);
	localparam logic [6:0] LEN_TOP   = 7'(MAX_LEN);

	// Configuration
	rlsu_pkg::cfg_t alpha_q, run_q, slen_q;
	rlsu_pkg::cfg_t a_c, r_c, n_c;

	// Counters and sequence state
	rlsu_pkg::cfg_t len_q, k_q, j_q, prev_q, crun_q;

	// Arithmetic registers
	rlsu_pkg::count_t acc_q, gprev_q, g_q, h_q, rank_q;

	// Leading-count store F and window-sum store W, registered reads
	rlsu_pkg::count_t f_mem [MAX_LEN];
	rlsu_pkg::count_t w_mem [WD];
	rlsu_pkg::count_t f_rd_q, w_rd_q;

	// Result registers
	rlsu_pkg::cfg_t sym_q;
	logic           last_q, err_q, val_q;

	logic [LW-1:0]    len_idx, f_addr, n_idx;
	logic [RW-1:0]    k_idx, r_idx, h_idx;
	logic [WAW-1:0]   w_wr_addr, w_rd_addr;
	logic             f_rd_en, w_rd_en, k_in;
	rlsu_pkg::count_t f_term, win_sum, cur_c;
	logic             gt, pick, same;

	assign a_c = rlsu_pkg::clamp_cfg(alpha_q, ALPHA_TOP);
	assign r_c = rlsu_pkg::clamp_cfg(run_q, RUN_TOP);
	assign n_c = rlsu_pkg::clamp_cfg(slen_q, LEN_TOP);

	// Address formation
	assign len_idx = LW'(len_q - 5'd1);
	assign n_idx   = LW'(n_c - 5'd1);
	assign f_addr  = LW'(len_q - k_q);
	assign k_idx   = RW'(k_q - 5'd1);
	assign r_idx   = RW'(r_c - 5'd1);
	assign h_idx   = RW'(r_c - crun_q - 5'd1);
	assign k_in    = (k_q <= len_q);

	assign w_wr_addr = WAW'(len_idx) * WAW'(MAX_RUN) + WAW'(k_idx);

	always_comb begin
		w_rd_addr = WAW'(len_idx) * WAW'(MAX_RUN) + WAW'(r_idx);
		case (op)
			rlsu_pkg::OP_T_READ: w_rd_addr = WAW'(n_idx) * WAW'(MAX_RUN) + WAW'(r_idx);
			rlsu_pkg::OP_G_TAKE: w_rd_addr = WAW'(len_idx) * WAW'(MAX_RUN) + WAW'(h_idx);
			default:             w_rd_addr = WAW'(len_idx) * WAW'(MAX_RUN) + WAW'(r_idx);
		endcase
	end

	assign f_rd_en = (op == rlsu_pkg::OP_W_READ) && k_in;
	assign w_rd_en = (op == rlsu_pkg::OP_T_READ) || (op == rlsu_pkg::OP_G_READ) ||
	                 (op == rlsu_pkg::OP_G_TAKE);

	// Window step: F entries before length 1 count as zero
	assign f_term  = k_in ? f_rd_q : '0;
	assign win_sum = rlsu_pkg::sat_add(acc_q, f_term);

	// Symbol scan: repeat of the previous symbol uses the shortened window
	assign same  = (j_q == prev_q);
	assign cur_c = same ? h_q : g_q;
	assign gt    = rank_q > cur_c;
	assign pick  = !gt || (j_q == a_c);

	// Status
	always_comb begin
		st.len_one  = (len_q == 5'd1);
		st.len_last = (len_q == n_c);
		st.a_one    = (a_c == 5'd1);
		st.f_done   = (j_q == a_c - 5'd1);
		st.k_last   = (k_q == r_c);
		st.j_last   = (j_q == a_c);
		st.rank_bad = (rank_q == '0) || (rank_q > acc_q);
		st.h_used   = (prev_q != '0) && (crun_q < r_c);
		st.pick     = pick;
		st.cfg_hit  = 1'b0;
		if (cfg_we) begin
			case (rlsu_pkg::reg_idx_t'(cfg_index))
				rlsu_pkg::REG_ALPHABET_SIZE,
				rlsu_pkg::REG_MAX_RUN,
				rlsu_pkg::REG_SEQ_LENGTH: st.cfg_hit = 1'b1;
				default:                  st.cfg_hit = 1'b0;
			endcase
		end
	end

	// Config registers, result strobe, sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= rlsu_pkg::cfg_t'(2);
			run_q   <= rlsu_pkg::cfg_t'(1);
			slen_q  <= rlsu_pkg::cfg_t'(1);
			val_q   <= 1'b0;
			prev_q  <= '0;
			crun_q  <= rlsu_pkg::cfg_t'(1);
		end else begin
			// strobe for an error beat or a picked symbol
			val_q <= ((op == rlsu_pkg::OP_T_CHECK) && st.rank_bad) ||
			         ((op == rlsu_pkg::OP_SCAN) && pick);
			if (cfg_we) begin
				case (rlsu_pkg::reg_idx_t'(cfg_index))
					rlsu_pkg::REG_ALPHABET_SIZE: alpha_q <= cfg_data;
					rlsu_pkg::REG_MAX_RUN:       run_q   <= cfg_data;
					rlsu_pkg::REG_SEQ_LENGTH:    slen_q  <= cfg_data;
					default: ;
				endcase
			end
			if (op == rlsu_pkg::OP_T_CHECK && !st.rank_bad) begin
				prev_q <= '0;
				crun_q <= rlsu_pkg::cfg_t'(1);
			end
			if (op == rlsu_pkg::OP_SCAN && pick) begin
				prev_q <= j_q;
				crun_q <= same ? crun_q + 5'd1 : rlsu_pkg::cfg_t'(1);
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (op)
			rlsu_pkg::OP_LOAD: begin
				rank_q <= rank;
				len_q  <= rlsu_pkg::cfg_t'(1);
			end
			rlsu_pkg::OP_F_START: begin
				acc_q <= (len_q == 5'd1) ? rlsu_pkg::count_t'(1) : '0;
				j_q   <= rlsu_pkg::cfg_t'(1);
			end
			rlsu_pkg::OP_F_ADD: begin
				acc_q <= rlsu_pkg::sat_add(acc_q, gprev_q);
				j_q   <= j_q + 5'd1;
			end
			rlsu_pkg::OP_F_WRITE: begin
				acc_q <= '0;
				k_q   <= rlsu_pkg::cfg_t'(1);
			end
			rlsu_pkg::OP_W_ACC: begin
				acc_q   <= win_sum;
				gprev_q <= win_sum;
				k_q     <= k_q + 5'd1;
			end
			rlsu_pkg::OP_LEN_NEXT: len_q <= len_q + 5'd1;
			rlsu_pkg::OP_T_READ: begin
				acc_q <= '0;
				j_q   <= rlsu_pkg::cfg_t'(1);
			end
			rlsu_pkg::OP_T_ADD: begin
				acc_q <= rlsu_pkg::sat_add(acc_q, w_rd_q);
				j_q   <= j_q + 5'd1;
			end
			rlsu_pkg::OP_T_CHECK: begin
				len_q  <= n_c;
				sym_q  <= '0;
				last_q <= 1'b1;
				err_q  <= 1'b1;
			end
			rlsu_pkg::OP_G_TAKE: begin
				g_q <= w_rd_q;
				h_q <= '0;
				j_q <= rlsu_pkg::cfg_t'(1);
			end
			rlsu_pkg::OP_H_TAKE: h_q <= w_rd_q;
			rlsu_pkg::OP_SCAN: begin
				if (gt)
					rank_q <= rank_q - cur_c;
				if (pick) begin
					sym_q  <= j_q;
					last_q <= (len_q == 5'd1);
					err_q  <= 1'b0;
					len_q  <= len_q - 5'd1;
				end else begin
					j_q <= j_q + 5'd1;
				end
			end
			default: ;
		endcase
	end

	// Count memories
	always_ff @(posedge clk) begin
		if (op == rlsu_pkg::OP_F_WRITE)
			f_mem[len_idx] <= acc_q;
		if (f_rd_en)
			f_rd_q <= f_mem[f_addr];
	end

	always_ff @(posedge clk) begin
		if (op == rlsu_pkg::OP_W_ACC)
			w_mem[w_wr_addr] <= win_sum;
		if (w_rd_en)
			w_rd_q <= w_mem[w_rd_addr];
	end

	assign result_valid = val_q;
	assign symbol       = sym_q;
	assign last         = last_q;
	assign error        = err_q;

endmodule

// File: rtl/run_limited_sequence_unranker.sv
// Top level of the run-limited sequence unranker: rlsu_ctrl sequencer plus rlsu_dp.
// Depends on rlsu_pkg, rlsu_ctrl and rlsu_dp.
//
//  channel  | signals                               | flow
//  ---------+---------------------------------------+----------------------------------
//  command  | start, busy, rank                     | beat taken when start && !busy
//  result   | result_valid, symbol, last, error     | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_index, cfg_data           | write when cfg_we, no wait
//
// After reset or a register write the first rank rebuilds the count store, each window
// step reading F through a register (W_READ, then W_ACC). Each rank then runs the total
// check over all symbols, and per output symbol two table reads (the second taken only
// when a repeat is allowed) and one scan step per symbol tried (up to a).
// Reset clears the sequencer and marks the count store stale; no clearing pass is needed.
// Results are never stalled; a new rank can be taken in the cycle showing the last beat.
`timescale 1ns / 1ps

module run_limited_sequence_unranker #(
	parameter int MAX_LEN   = rlsu_pkg::MAX_LEN_DEF,
	parameter int MAX_ALPHA = rlsu_pkg::MAX_ALPHA_DEF,
	parameter int MAX_RUN   = rlsu_pkg::MAX_RUN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  rlsu_pkg::count_t           rank,
	input  logic                       cfg_we,
	input  logic [rlsu_pkg::IDX_W-1:0] cfg_index,
	input  rlsu_pkg::cfg_t             cfg_data,
	output logic                       result_valid,
	output rlsu_pkg::cfg_t             symbol,
	output logic                       last,
	output logic                       error
);

	rlsu_pkg::dp_op_t  op;
	rlsu_pkg::status_t st;

	rlsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.op     (op),
		.busy   (busy)
	);

	rlsu_dp #(
		.MAX_LEN   (MAX_LEN),
		.MAX_ALPHA (MAX_ALPHA),
		.MAX_RUN   (MAX_RUN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.rank         (rank),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.st           (st),
		.result_valid (result_valid),
		.symbol       (symbol),
		.last         (last),
		.error        (error)
	);

	// Result beats never come in consecutive cycles
	a_beat_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result beats in consecutive cycles");

	// Going idle always coincides with the final beat of a rank
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && last))
		else $error("returned to idle without a final beat");

	// An error beat is a lone final beat with symbol zero
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && error) |-> (last && symbol == '0))
		else $error("malformed error beat");

	// An accepted rank keeps the block busy on the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted but block not busy");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for run_limited_sequence_unranker: directed and random ranks
// over several register settings, checked against an in-bench count-table decoder.
// Depends on rlsu_pkg and the run_limited_sequence_unranker RTL.
`timescale 1ns / 1ps

module tb_top;

	// No register lives at this index; writes to it must be ignored
	localparam logic [rlsu_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int MAX_SHOWN = 60;

	typedef struct {
		rlsu_pkg::cfg_t symbol;
		logic last;
		logic error;
	} symbol_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	rlsu_pkg::count_t rank = '0;
	logic cfg_we = 1'b0;
	logic [rlsu_pkg::IDX_W-1:0] cfg_index = '0;
	rlsu_pkg::cfg_t cfg_data = '0;
	logic busy;
	logic result_valid;
	rlsu_pkg::cfg_t symbol;
	logic last;
	logic error;

	run_limited_sequence_unranker dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.rank(rank),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.symbol(symbol),
		.last(last),
		.error(error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state: raw registers, their effective values and the suffix counts
	rlsu_pkg::cfg_t alpha_reg = rlsu_pkg::cfg_t'(2);
	rlsu_pkg::cfg_t run_reg = rlsu_pkg::cfg_t'(1);
	rlsu_pkg::cfg_t len_reg = rlsu_pkg::cfg_t'(1);
	int alpha_eff, run_eff, len_eff;
	rlsu_pkg::count_t suffix_count [0:rlsu_pkg::MAX_LEN_DEF][1:rlsu_pkg::MAX_ALPHA_DEF]
		[1:rlsu_pkg::MAX_RUN_DEF];
	rlsu_pkg::count_t seq_total;

	rlsu_pkg::count_t pending_ranks[$];
	symbol_beat_t expected_symbols[$];
	int mismatch_count = 0;
	int burst_left = 0;
	int gap_left = 0;

	function automatic rlsu_pkg::count_t add_capped(input rlsu_pkg::count_t x,
		input rlsu_pkg::count_t y);
		logic [rlsu_pkg::CNT_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[rlsu_pkg::CNT_W] ? rlsu_pkg::count_t'('1) : s[rlsu_pkg::CNT_W-1:0];
	endfunction

	function automatic int clamp_setting(input rlsu_pkg::cfg_t v, input int top);
		if (v == '0)
			return 1;
		if (int'(v) > top)
			return top;
		return int'(v);
	endfunction

	// Counts of valid suffixes by length, leading symbol and exact leading run
	task automatic rebuild_counts();
		rlsu_pkg::count_t c;
		alpha_eff = clamp_setting(alpha_reg, rlsu_pkg::MAX_ALPHA_DEF);
		run_eff = clamp_setting(run_reg, rlsu_pkg::MAX_RUN_DEF);
		len_eff = clamp_setting(len_reg, rlsu_pkg::MAX_LEN_DEF);
		for (int n = 0; n <= rlsu_pkg::MAX_LEN_DEF; n++)
			for (int s = 1; s <= rlsu_pkg::MAX_ALPHA_DEF; s++)
				for (int k = 1; k <= rlsu_pkg::MAX_RUN_DEF; k++)
					suffix_count[n][s][k] = '0;
		for (int n = 1; n <= len_eff; n++) begin
			for (int j = 1; j <= alpha_eff; j++) begin
				c = '0;
				if (n == 1) begin
					c = rlsu_pkg::count_t'(1);
				end else begin
					for (int s = 1; s <= alpha_eff; s++)
						if (s != j)
							for (int k = 1; k <= run_eff; k++)
								c = add_capped(c, suffix_count[n-1][s][k]);
				end
				suffix_count[n][j][1] = c;
				for (int k = 2; k <= run_eff && k <= n; k++)
					suffix_count[n][j][k] = suffix_count[n-k+1][j][1];
			end
		end
		seq_total = '0;
		for (int j = 1; j <= alpha_eff; j++)
			for (int k = 1; k <= run_eff; k++)
				seq_total = add_capped(seq_total, suffix_count[len_eff][j][k]);
	endtask

	// Expected symbol beats for one accepted rank
	task automatic decode_rank(input rlsu_pkg::count_t want_rank);
		symbol_beat_t beat;
		rlsu_pkg::count_t left;
		rlsu_pkg::count_t span;
		int prev, run, pick;
		left = want_rank;
		if (want_rank == '0 || want_rank > seq_total) begin
			beat.symbol = '0;
			beat.last = 1'b1;
			beat.error = 1'b1;
			expected_symbols.push_back(beat);
			return;
		end
		prev = 0;
		run = 1;
		for (int pos = len_eff; pos >= 1; pos--) begin
			pick = alpha_eff;
			for (int j = 1; j <= alpha_eff; j++) begin
				span = '0;
				for (int k = 1; k <= run_eff; k++)
					if (j != prev || run + k <= run_eff)
						span = add_capped(span, suffix_count[pos][j][k]);
				if (left > span) begin
					left = left - span;
				end else begin
					pick = j;
					break;
				end
			end
			run = (pick == prev) ? run + 1 : 1;
			prev = pick;
			beat.symbol = rlsu_pkg::cfg_t'(pick);
			beat.last = (pos == 1);
			beat.error = 1'b0;
			expected_symbols.push_back(beat);
		end
	endtask

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_SHOWN)
			$display("%0t: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic int draw_gap();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return $urandom_range(1, 8);
			2: return $urandom_range(1, 60);
			default: return $urandom_range(1, 400);
		endcase
	endfunction

	// Mostly valid ranks, some zero, at the total or beyond it
	function automatic rlsu_pkg::count_t draw_rank();
		rlsu_pkg::count_t raw;
		raw = rlsu_pkg::count_t'({$urandom, $urandom});
		if (seq_total == '0)
			return raw;
		case ($urandom_range(0, 9))
			0: return '0;
			1: begin
				if (seq_total == rlsu_pkg::count_t'('1))
					return seq_total;
				return seq_total + 1 + raw % (rlsu_pkg::count_t'('1) - seq_total);
			end
			2: return seq_total;
			default: return raw % seq_total + 1;
		endcase
	endfunction

	function automatic rlsu_pkg::cfg_t draw_setting();
		if ($urandom_range(0, 5) == 0)
			return rlsu_pkg::cfg_t'($urandom_range(0, 31));
		return rlsu_pkg::cfg_t'($urandom_range(1, 16));
	endfunction

	// Command driver: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			rank <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				decode_rank(rank);
			if (start && busy) begin
				// hold the beat until taken
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_ranks.size() > 0) begin
				start <= 1'b1;
				rank <= pending_ranks.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= draw_gap();
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		symbol_beat_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (expected_symbols.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, symbol %0d", symbol));
			end else begin
				want = expected_symbols.pop_front();
				if (symbol !== want.symbol)
					report_mismatch($sformatf("symbol %0d, want %0d", symbol, want.symbol));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b", last, want.last));
				if (error !== want.error)
					report_mismatch($sformatf("error %b, want %b", error, want.error));
			end
		end
	end

	task automatic write_reg(input logic [rlsu_pkg::IDX_W-1:0] idx, input rlsu_pkg::cfg_t value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			rlsu_pkg::REG_ALPHABET_SIZE: alpha_reg = value;
			rlsu_pkg::REG_MAX_RUN: run_reg = value;
			rlsu_pkg::REG_SEQ_LENGTH: len_reg = value;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		rebuild_counts();
	endtask

	task automatic set_regs(input rlsu_pkg::cfg_t a, input rlsu_pkg::cfg_t r,
		input rlsu_pkg::cfg_t n);
		write_reg(rlsu_pkg::REG_ALPHABET_SIZE, a);
		write_reg(rlsu_pkg::REG_MAX_RUN, r);
		write_reg(rlsu_pkg::REG_SEQ_LENGTH, n);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_ranks.size() != 0 || start || busy || expected_symbols.size() != 0);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		rebuild_counts();

		// Reset settings: two symbols, run one, length one
		pending_ranks.push_back(rlsu_pkg::count_t'(0));
		pending_ranks.push_back(rlsu_pkg::count_t'(1));
		pending_ranks.push_back(rlsu_pkg::count_t'(2));
		pending_ranks.push_back(rlsu_pkg::count_t'(3));
		wait_idle();

		// Out-of-range writes clamp: 16 symbols, run 1, length 16
		set_regs(5'd31, 5'd0, 5'd16);
		end_writes();
		pending_ranks.push_back(rlsu_pkg::count_t'(1));
		pending_ranks.push_back(seq_total);
		pending_ranks.push_back(seq_total + 1);
		pending_ranks.push_back(rlsu_pkg::count_t'('1));
		wait_idle();

		// Largest sizes, total saturates; spare index must not disturb anything
		set_regs(5'd16, 5'd16, 5'd16);
		write_reg(REG_SPARE, 5'd3);
		end_writes();
		pending_ranks.push_back(rlsu_pkg::count_t'('1));
		pending_ranks.push_back(rlsu_pkg::count_t'(1));
		pending_ranks.push_back(rlsu_pkg::count_t'('1) - 1);
		wait_idle();

		// Single symbol with a long enough run: exactly one sequence
		set_regs(5'd1, 5'd16, 5'd16);
		end_writes();
		pending_ranks.push_back(rlsu_pkg::count_t'(1));
		pending_ranks.push_back(rlsu_pkg::count_t'(2));
		wait_idle();

		// Zero alphabet reads as one, run too short: no valid sequence at all
		set_regs(5'd0, 5'd1, 5'd2);
		end_writes();
		pending_ranks.push_back(rlsu_pkg::count_t'(1));
		pending_ranks.push_back(rlsu_pkg::count_t'(0));
		wait_idle();

		// Run above the top clamps, zero length reads as one
		set_regs(5'd16, 5'd17, 5'd0);
		end_writes();
		pending_ranks.push_back(rlsu_pkg::count_t'(16));
		pending_ranks.push_back(rlsu_pkg::count_t'(17));
		wait_idle();

		// Random settings between fixed first and last phases, each with a batch of random ranks
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				set_regs(5'd31, 5'd31, 5'd31);
			end else if (ph == 7) begin
				set_regs(5'd1, 5'd1, 5'd1);
			end else begin
				if ($urandom_range(0, 3) != 0)
					write_reg(rlsu_pkg::REG_ALPHABET_SIZE, draw_setting());
				if ($urandom_range(0, 3) != 0)
					write_reg(rlsu_pkg::REG_MAX_RUN, draw_setting());
				if ($urandom_range(0, 3) != 0)
					write_reg(rlsu_pkg::REG_SEQ_LENGTH, draw_setting());
				if ($urandom_range(0, 3) == 0)
					write_reg(REG_SPARE, rlsu_pkg::cfg_t'($urandom_range(0, 31)));
			end
			end_writes();
			for (int i = 0; i < 12; i++)
				pending_ranks.push_back(draw_rank());
			wait_idle();
		end

		// Trailing window catches stray beats
		repeat (50) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
